FILE: design/preemptive_priority_scheduler_defines.svh
// assertion macros for the preemptive priority scheduler checker
// no dependencies
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define PPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/pps_pkg.sv
// shared types and constants for the preemptive priority scheduler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    localparam int MAX_TASKS_DEF = 32;
    localparam int IDX_W         = 8;
    localparam int TIME_W        = 22;
    localparam int FIELD_W       = 16;
    localparam int PRIO_W        = 8;
    localparam int SLOT_W        = 5;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic
    {
        ST_IDLE,
        ST_SCAN
    } pps_state_t;

    typedef enum logic
    {
        ACT_LOAD = 1'b0,
        ACT_TICK = 1'b1
    } pps_action_t;

    typedef struct packed
    {
        logic               valid;
        logic [IDX_W-1:0]   slot;
        logic [PRIO_W-1:0]  prio;
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] burst;
        logic [FIELD_W-1:0] rem;
        logic [1:0]         pend;
    } pps_scan_t;

    typedef struct packed
    {
        logic               en;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } pps_load_t;

    typedef struct packed
    {
        logic             en;
        logic [IDX_W-1:0] slot;
    } pps_dec_t;

endpackage

`default_nettype wire

FILE: design/pps_cell.sv
// one task slot of the scheduler chain, with its stage of the candidate scan
// depends on pps_pkg
`timescale 1ns / 1ps
`default_nettype none

module pps_cell
#(
    parameter int IDX = 0
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire pps_pkg::pps_scan_t         scan_in,
    output pps_pkg::pps_scan_t              scan_out,
    input  wire logic [pps_pkg::TIME_W-1:0] now,
    input  wire pps_pkg::pps_load_t         ld,
    input  wire pps_pkg::pps_dec_t          dec
);
    import pps_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic               loaded_reg, loaded_next;
    logic               done_reg, done_next;
    logic [FIELD_W-1:0] arr_reg, arr_next;
    logic [FIELD_W-1:0] burst_reg, burst_next;
    logic [PRIO_W-1:0]  prio_reg, prio_next;
    logic [FIELD_W-1:0] rem_reg, rem_next;
    pps_scan_t          scan_reg, scan_next;

    logic own_pend;
    logic own_rdy;
    logic take;
    logic ld_hit;
    logic dec_hit;

    always_comb
    begin
        own_pend = loaded_reg & ~done_reg;
        own_rdy  = own_pend && ({{(TIME_W-FIELD_W){1'b0}}, arr_reg} <= now);
        take     = own_rdy && (!scan_in.valid || (prio_reg < scan_in.prio));

        scan_next = scan_in;
        if (take)
        begin
            scan_next.valid   = 1'b1;
            scan_next.slot    = MY_IDX;
            scan_next.prio    = prio_reg;
            scan_next.arrival = arr_reg;
            scan_next.burst   = burst_reg;
            scan_next.rem     = rem_reg;
        end
        if (scan_in.pend == 2'd2)
            scan_next.pend = 2'd2;
        else
            scan_next.pend = scan_in.pend + {1'b0, own_pend};
    end

    always_comb
    begin
        ld_hit  = ld.en && ({{(IDX_W-SLOT_W){1'b0}}, ld.slot} == MY_IDX);
        dec_hit = dec.en && (dec.slot == MY_IDX);

        loaded_next = loaded_reg;
        done_next   = done_reg;
        arr_next    = arr_reg;
        burst_next  = burst_reg;
        prio_next   = prio_reg;
        rem_next    = rem_reg;

        if (ld_hit)
        begin
            loaded_next = 1'b1;
            done_next   = 1'b0;
            arr_next    = ld.arrival;
            burst_next  = ld.burst;
            prio_next   = ld.prio;
            rem_next    = ld.burst;
        end
        else if (dec_hit)
        begin
            if (rem_reg != '0)
                rem_next = rem_reg - FIELD_W'(1);
            if (rem_reg <= FIELD_W'(1))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
            done_reg   <= 1'b0;
            scan_reg   <= '0;
        end
        else
        begin
            loaded_reg <= loaded_next;
            done_reg   <= done_next;
            scan_reg   <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        arr_reg   <= arr_next;
        burst_reg <= burst_next;
        prio_reg  <= prio_next;
        rem_reg   <= rem_next;
    end

    assign scan_out = scan_reg;

endmodule

`default_nettype wire

FILE: design/preemptive_priority_scheduler.sv
// top level of the preemptive priority scheduler: control, time counter, cell chain
// depends on pps_pkg and pps_cell
//
// channel   handshake                 payload
// command   start, busy               action, slot, arrival, burst, priority_req
// result    result_valid (strobe)     ran_valid, ran_slot, finished, completion_time,
//                                     turnaround_time, waiting_time, all_done, current_time
//
// a load transaction is applied while busy stays low
// a tick transaction raises busy while the best candidate walks the cell
// chain one slot per cycle, then the result strobes for one cycle while busy is low
// reset clears the time counter and all loaded and done flags
// the receiver cannot stall; results are never held
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_scheduler
#(
    parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        action,
    input  wire logic [pps_pkg::SLOT_W-1:0]  slot,
    input  wire logic [pps_pkg::FIELD_W-1:0] arrival,
    input  wire logic [pps_pkg::FIELD_W-1:0] burst,
    input  wire logic [pps_pkg::PRIO_W-1:0]  priority_req,
    output logic                             result_valid,
    output logic                             ran_valid,
    output logic [pps_pkg::SLOT_W-1:0]       ran_slot,
    output logic                             finished,
    output logic [pps_pkg::TIME_W-1:0]       completion_time,
    output logic [pps_pkg::TIME_W-1:0]       turnaround_time,
    output logic [pps_pkg::TIME_W-1:0]       waiting_time,
    output logic                             all_done,
    output logic [pps_pkg::TIME_W-1:0]       current_time
);
    import pps_pkg::*;

    localparam int CW = $clog2(MAX_TASKS);
    localparam logic [CW-1:0] CNT_LAST = CW'(MAX_TASKS - 1);

    pps_state_t          state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic                strobe_reg, strobe_next;
    logic                ran_reg, ran_next;
    logic [SLOT_W-1:0]   rslot_reg, rslot_next;
    logic                fin_reg, fin_next;
    logic [TIME_W-1:0]   ct_reg, ct_next;
    logic [TIME_W-1:0]   tat_reg, tat_next;
    logic [TIME_W-1:0]   wt_reg, wt_next;
    logic                alld_reg, alld_next;

    pps_scan_t           chain [0:MAX_TASKS];
    pps_load_t           ld;
    pps_dec_t            dec;

    logic                accept;
    logic                scan_end;
    logic [TIME_W-1:0]   now_inc;
    logic [TIME_W-1:0]   tat;
    logic [TIME_W-1:0]   burst_x;
    logic                fin;
    pps_scan_t           last;

    assign chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++)
        begin : g_cell
            pps_cell
            #(
                .IDX (gi)
            )
            u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .scan_in  (chain[gi]),
                .scan_out (chain[gi+1]),
                .now      (now_reg),
                .ld       (ld),
                .dec      (dec)
            );
        end
    endgenerate

    assign last = chain[MAX_TASKS];

    always_comb
    begin
        accept     = start && (state_reg == ST_IDLE);
        ld.en      = accept && (pps_action_t'(action) == ACT_LOAD);
        ld.slot    = slot;
        ld.arrival = arrival;
        ld.burst   = (burst == '0) ? FIELD_W'(1) : burst;
        ld.prio    = priority_req;

        scan_end = (state_reg == ST_SCAN) && (cnt_reg == CNT_LAST);
        now_inc  = (now_reg == TIME_MAX) ? now_reg : now_reg + TIME_W'(1);
        fin      = (last.rem <= FIELD_W'(1));
        tat      = now_inc - {{(TIME_W-FIELD_W){1'b0}}, last.arrival};
        burst_x  = {{(TIME_W-FIELD_W){1'b0}}, last.burst};

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        now_next    = now_reg;
        strobe_next = 1'b0;
        ran_next    = ran_reg;
        rslot_next  = rslot_reg;
        fin_next    = fin_reg;
        ct_next     = ct_reg;
        tat_next    = tat_reg;
        wt_next     = wt_reg;
        alld_next   = alld_reg;
        dec.en      = 1'b0;
        dec.slot    = last.slot;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (pps_action_t'(action) == ACT_TICK))
                begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (scan_end)
                begin
                    state_next  = ST_IDLE;
                    strobe_next = 1'b1;
                    ran_next    = 1'b0;
                    rslot_next  = '0;
                    fin_next    = 1'b0;
                    ct_next     = '0;
                    tat_next    = '0;
                    wt_next     = '0;
                    if (last.pend == 2'd0)
                    begin
                        alld_next = 1'b1;
                    end
                    else
                    begin
                        now_next  = now_inc;
                        alld_next = 1'b0;
                        if (last.valid)
                        begin
                            dec.en     = 1'b1;
                            ran_next   = 1'b1;
                            rslot_next = SLOT_W'(last.slot);
                            if (fin)
                            begin
                                fin_next  = 1'b1;
                                ct_next   = now_inc;
                                tat_next  = tat;
                                wt_next   = (tat >= burst_x) ? tat - burst_x : '0;
                                alld_next = (last.pend == 2'd1);
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            now_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            now_reg    <= now_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ran_reg   <= ran_next;
        rslot_reg <= rslot_next;
        fin_reg   <= fin_next;
        ct_reg    <= ct_next;
        tat_reg   <= tat_next;
        wt_reg    <= wt_next;
        alld_reg  <= alld_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign result_valid    = strobe_reg;
    assign ran_valid       = ran_reg;
    assign ran_slot        = rslot_reg;
    assign finished        = fin_reg;
    assign completion_time = ct_reg;
    assign turnaround_time = tat_reg;
    assign waiting_time    = wt_reg;
    assign all_done        = alld_reg;
    assign current_time    = now_reg;

endmodule

`default_nettype wire

FILE: design/pps_checker.sv
// port-level checker for the preemptive priority scheduler, bound to the top level
// depends on pps_pkg and preemptive_priority_scheduler_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "preemptive_priority_scheduler_defines.svh"

module pps_checker
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       action,
    input wire logic                       result_valid,
    input wire logic                       ran_valid,
    input wire logic                       finished,
    input wire logic [pps_pkg::TIME_W-1:0] completion_time,
    input wire logic [pps_pkg::TIME_W-1:0] turnaround_time,
    input wire logic [pps_pkg::TIME_W-1:0] current_time
);
    import pps_pkg::*;

    `PPS_ASSERT_NXT(a_tick_busy, clk, rst_n, start && !busy && (pps_action_t'(action) == ACT_TICK), busy, "tick transaction did not raise busy")
    `PPS_ASSERT_NOW(a_strobe_idle, clk, rst_n, result_valid, !busy, "result strobe while busy")
    `PPS_ASSERT_NOW(a_fin_ran, clk, rst_n, result_valid && finished, ran_valid, "finish without a task run")
    `PPS_ASSERT_NOW(a_ct_now, clk, rst_n, result_valid && finished, completion_time == current_time, "completion time differs from time")
    `PPS_ASSERT_NOW(a_tat_le, clk, rst_n, result_valid && finished, turnaround_time <= completion_time, "turnaround exceeds completion time")

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .result_valid    (result_valid),
    .ran_valid       (ran_valid),
    .finished        (finished),
    .completion_time (completion_time),
    .turnaround_time (turnaround_time),
    .current_time    (current_time)
);

`default_nettype wire

FILE: sim/preemptive_priority_scheduler_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the preemptive priority scheduler: queued commands, own predictor
// depends on pps_pkg and preemptive_priority_scheduler

module preemptive_priority_scheduler_tb;
    import pps_pkg::*;

    localparam int NUM_SLOTS   = MAX_TASKS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 650;

    typedef struct packed
    {
        logic               drain_first;
        pps_action_t        act;
        logic [SLOT_W-1:0]  slot;
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } sched_cmd_t;

    typedef struct packed
    {
        logic              ran_valid;
        logic [SLOT_W-1:0] ran_slot;
        logic              finished;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] waiting_time;
        logic              all_done;
        logic [TIME_W-1:0] current_time;
    } sched_report_t;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                start        = 1'b0;
    logic                action       = 1'b0;
    logic [SLOT_W-1:0]   slot         = '0;
    logic [FIELD_W-1:0]  arrival      = '0;
    logic [FIELD_W-1:0]  burst        = '0;
    logic [PRIO_W-1:0]   priority_req = '0;
    logic                busy;
    logic                result_valid;
    logic                ran_valid;
    logic [SLOT_W-1:0]   ran_slot;
    logic                finished;
    logic [TIME_W-1:0]   completion_time;
    logic [TIME_W-1:0]   turnaround_time;
    logic [TIME_W-1:0]   waiting_time;
    logic                all_done;
    logic [TIME_W-1:0]   current_time;

    // predicted scheduler state
    logic [TIME_W-1:0]   sched_now = '0;
    bit                  task_loaded  [NUM_SLOTS];
    bit                  task_done    [NUM_SLOTS];
    logic [FIELD_W-1:0]  task_arrival [NUM_SLOTS];
    logic [FIELD_W-1:0]  task_burst   [NUM_SLOTS];
    logic [PRIO_W-1:0]   task_prio    [NUM_SLOTS];
    logic [FIELD_W-1:0]  task_left    [NUM_SLOTS];

    sched_cmd_t          cmd_queue[$];
    sched_report_t       expected_ticks[$];
    int                  fail_count   = 0;
    int                  cycle_count  = 0;
    int                  gap_left     = 0;
    int                  items_queued = 0;
    int                  plan_now     = 0;
    bit                  gapless      = 1'b0;
    bit                  drain_next   = 1'b0;
    logic                cmd_taken    = 1'b0;

    preemptive_priority_scheduler dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .slot            (slot),
        .arrival         (arrival),
        .burst           (burst),
        .priority_req    (priority_req),
        .result_valid    (result_valid),
        .ran_valid       (ran_valid),
        .ran_slot        (ran_slot),
        .finished        (finished),
        .completion_time (completion_time),
        .turnaround_time (turnaround_time),
        .waiting_time    (waiting_time),
        .all_done        (all_done),
        .current_time    (current_time)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic bit nothing_pending();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (task_loaded[i] && !task_done[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic schedule_step(input sched_cmd_t c);
        sched_report_t      r;
        int                 pick;
        logic [FIELD_W-1:0] b;
        logic [TIME_W-1:0]  tat;
        if (c.act == ACT_LOAD)
        begin
            b = (c.burst == '0) ? FIELD_W'(1) : c.burst;
            task_loaded[c.slot]  = 1'b1;
            task_done[c.slot]    = 1'b0;
            task_arrival[c.slot] = c.arrival;
            task_burst[c.slot]   = b;
            task_prio[c.slot]    = c.prio;
            task_left[c.slot]    = b;
        end
        else
        begin
            r = '0;
            if (nothing_pending())
            begin
                r.all_done     = 1'b1;
                r.current_time = sched_now;
            end
            else
            begin
                pick = -1;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (task_loaded[i] && !task_done[i] && task_arrival[i] <= sched_now)
                    begin
                        if (pick < 0 || task_prio[i] < task_prio[pick])
                            pick = i;
                    end
                end
                if (sched_now != TIME_MAX)
                    sched_now = sched_now + 1'b1;
                if (pick >= 0)
                begin
                    r.ran_valid = 1'b1;
                    r.ran_slot  = SLOT_W'(pick);
                    if (task_left[pick] != '0)
                        task_left[pick] = task_left[pick] - 1'b1;
                    if (task_left[pick] == '0)
                    begin
                        tat = sched_now - task_arrival[pick];
                        task_done[pick]   = 1'b1;
                        r.finished        = 1'b1;
                        r.completion_time = sched_now;
                        r.turnaround_time = tat;
                        r.waiting_time    = (tat >= task_burst[pick])
                                            ? tat - task_burst[pick] : '0;
                    end
                end
                r.all_done     = nothing_pending();
                r.current_time = sched_now;
            end
            expected_ticks.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        sched_report_t want;
        sched_cmd_t    seen;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_ticks.size() == 0)
                begin
                    $error("result strobe with no tick outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    check_field("ran_valid", TIME_W'(want.ran_valid), TIME_W'(ran_valid));
                    check_field("ran_slot", TIME_W'(want.ran_slot), TIME_W'(ran_slot));
                    check_field("finished", TIME_W'(want.finished), TIME_W'(finished));
                    check_field("completion_time", want.completion_time, completion_time);
                    check_field("turnaround_time", want.turnaround_time, turnaround_time);
                    check_field("waiting_time", want.waiting_time, waiting_time);
                    check_field("all_done", TIME_W'(want.all_done), TIME_W'(all_done));
                    check_field("current_time", want.current_time, current_time);
                end
            end
            if (start && !busy)
            begin
                seen         = '0;
                seen.act     = pps_action_t'(action);
                seen.slot    = slot;
                seen.arrival = arrival;
                seen.burst   = burst;
                seen.prio    = priority_req;
                schedule_step(seen);
            end
            cmd_taken <= start && !busy;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(negedge clk)
    begin : command_driver
        sched_cmd_t nxt;
        logic       drive_start;
        if (rst_n)
        begin
            drive_start = start && !cmd_taken;
            if (!drive_start)
            begin
                if (gap_left > 0)
                    gap_left = gap_left - 1;
                else if (cmd_queue.size() > 0
                         && !(cmd_queue[0].drain_first && expected_ticks.size() > 0))
                begin
                    nxt = cmd_queue.pop_front();
                    action       <= nxt.act;
                    slot         <= nxt.slot;
                    arrival      <= nxt.arrival;
                    burst        <= nxt.burst;
                    priority_req <= nxt.prio;
                    drive_start  = 1'b1;
                    gap_left     = pick_gap();
                end
            end
            start <= drive_start;
        end
    end

    task automatic push_load(input int s, input int arr, input int b, input int p);
        sched_cmd_t c;
        c             = '0;
        c.drain_first = drain_next;
        c.act         = ACT_LOAD;
        c.slot        = SLOT_W'(s);
        c.arrival     = FIELD_W'(arr);
        c.burst       = FIELD_W'(b);
        c.prio        = PRIO_W'(p);
        drain_next    = 1'b0;
        cmd_queue.push_back(c);
        items_queued++;
    endtask

    task automatic push_tick(input int n);
        sched_cmd_t c;
        repeat (n)
        begin
            c             = '0;
            c.drain_first = drain_next;
            c.act         = ACT_TICK;
            drain_next    = 1'b0;
            cmd_queue.push_back(c);
            items_queued++;
            plan_now++;
        end
    endtask

    task automatic wait_queue_empty();
        while (cmd_queue.size() != 0 || (start && !cmd_taken))
        begin
            @(posedge clk);
            #1;
        end
    endtask

    initial
    begin : stimulus
        int s;
        int b;
        int need;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table, zero burst, far arrival, tie on priority, idle tick
        push_tick(1);
        push_load(0, 0, 0, 255);
        push_load(31, 16'hFFFF, 16'hFFFF, 0);
        push_load(5, 0, 2, 7);
        push_load(9, 0, 2, 7);
        push_tick(6);
        // late arrival, then a more urgent task preempts it
        push_load(3, 8, 3, 100);
        push_tick(3);
        push_load(4, 0, 1, 1);
        push_tick(3);
        // reload of a slot clears the far task
        push_load(31, 0, 1, 0);
        push_tick(2);

        drain_next = 1'b1;
        while (items_queued < ITEM_TARGET)
        begin
            wait_queue_empty();
            plan_now = int'(sched_now);
            gapless  = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                drain_next = 1'b1;
            if ($urandom_range(0, 9) == 0)
            begin
                s = $urandom_range(0, NUM_SLOTS - 1);
                push_load(s, $urandom, $urandom, $urandom);
                push_tick($urandom_range(0, 4));
                push_load(s, 0, 1, $urandom);
                push_tick(3);
            end
            else
            begin
                need = 14 + $urandom_range(0, 3);
                repeat ($urandom_range(1, 6))
                begin
                    b = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(0, 5);
                    push_load($urandom_range(0, NUM_SLOTS - 1),
                              plan_now + $urandom_range(0, 12), b,
                              $urandom_range(0, 1) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 255));
                    need += (b == 0) ? 1 : b;
                end
                while (need > 0)
                begin
                    if ($urandom_range(0, 11) == 0)
                    begin
                        b = $urandom_range(1, 4);
                        push_load($urandom_range(0, NUM_SLOTS - 1),
                                  plan_now + $urandom_range(0, 5), b,
                                  $urandom_range(0, 255));
                        need += b;
                    end
                    push_tick(1);
                    need--;
                end
            end
        end

        wait_queue_empty();
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (NUM_SLOTS + 8) @(posedge clk);
        if (fail_count == 0 && expected_ticks.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
